### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define CHK_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

### rtl/m3i_pkg.sv
// types, constants and saturation helper for the 3x3 matrix inverse
package m3i_pkg;

  localparam int ELEM_W = 32;
  localparam int PROD_W = 64;
  localparam int COF_W  = 65;
  localparam int CMAG_W = 64;
  localparam int DET_W  = 97;
  localparam int DMAG_W = 96;
  localparam int Q_W    = 32;
  localparam int N_ENT  = 9;
  localparam int N_PROD = 18;
  localparam int N_DIV  = Q_W;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [N_ENT-1:0] mat_t;

  // element indexes of the two products of each adjugate entry, row-major
  localparam logic [3:0] COF_IDX [N_ENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // one item inside the quotient pipeline
  typedef struct packed {
    logic [N_ENT-1:0][DMAG_W-1:0] rem;
    logic [N_ENT-1:0][Q_W-1:0]    q;
    logic [N_ENT-1:0]             neg;
    logic [N_ENT-1:0]             ovf;
    logic [DMAG_W-1:0]            dmag;
    elem_t                        det_q;
    logic                         det_sat;
    logic                         sing;
  } div_t;

  // one finished result item
  typedef struct packed {
    mat_t  r;
    elem_t det;
    logic  sing;
    logic  sat;
  } res_t;

  typedef struct packed {
    elem_t val;
    logic  sat;
  } sat_t;

  // clip a sign-magnitude value to 32-bit two's complement
  function automatic sat_t sat32(input logic [CMAG_W-1:0] m, input logic neg,
                                 input logic ovf);
    sat_t r;
    r.sat = 1'b0;
    r.val = '0;
    if (neg) begin
      if (ovf || m > CMAG_W'(64'h8000_0000)) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = ~m[ELEM_W-1:0] + 1'b1;
      end
    end else begin
      if (ovf || m > CMAG_W'(64'h7FFF_FFFF)) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = m[ELEM_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

### rtl/m3i_in_if.sv
// input channel: one matrix per item
interface m3i_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

### rtl/m3i_out_if.sv
// result channel: inverse, determinant and flags per item
interface m3i_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [31:0] det_out;
  logic               singular;
  logic               saturated;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_out, singular, saturated, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_out, singular, saturated, output ready);
endinterface

### rtl/matrix3x3_inverse.sv
// top level of the pipelined 3x3 matrix inverse
//
//   channel   dir   handshake            payload
//   in_ch     in    valid / ready        a00..a22, signed Q16.16
//   out_ch    out   valid / ready        r00..r22, det_out, singular, saturated
//
// one matrix enters per cycle while in_ch.ready is high; the design has six
// front stages (products, adjugate, split multiply, partial sums, determinant,
// divider setup), 32 one-quotient-bit divider stages and one output register.
// reset (synchronous, active low) clears only the stage valid bits.
// each stage holds while its successor is full and stalled; empty stages keep
// filling, so input is taken while a result waits if any stage is empty.
module matrix3x3_inverse (
  input logic      clk,
  input logic      rst_n,
  m3i_in_if.sink   in_ch,
  m3i_out_if.source out_ch
);

  localparam int N_DIV = m3i_pkg::N_DIV;

  m3i_pkg::mat_t  mat;
  m3i_pkg::div_t  dch [N_DIV+1];
  logic           vch [N_DIV+1];
  logic           rch [N_DIV+1];
  m3i_pkg::res_t  res;
  logic           f_ready;

  // gather the input item
  assign mat[0] = in_ch.a00;
  assign mat[1] = in_ch.a01;
  assign mat[2] = in_ch.a02;
  assign mat[3] = in_ch.a10;
  assign mat[4] = in_ch.a11;
  assign mat[5] = in_ch.a12;
  assign mat[6] = in_ch.a20;
  assign mat[7] = in_ch.a21;
  assign mat[8] = in_ch.a22;
  assign in_ch.ready = f_ready;

  m3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (f_ready),
    .mat       (mat),
    .out_valid (vch[0]),
    .out_ready (rch[0]),
    .out_d     (dch[0])
  );

  // quotient pipeline, most significant bit first
  for (genvar i = 0; i < N_DIV; i++) begin : g_div
    m3i_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vch[i]),
      .in_ready  (rch[i]),
      .in_d      (dch[i]),
      .out_valid (vch[i+1]),
      .out_ready (rch[i+1]),
      .out_d     (dch[i+1])
    );
  end

  m3i_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vch[N_DIV]),
    .in_ready  (rch[N_DIV]),
    .in_d      (dch[N_DIV]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // scatter the result item
  assign out_ch.r00       = res.r[0];
  assign out_ch.r01       = res.r[1];
  assign out_ch.r02       = res.r[2];
  assign out_ch.r10       = res.r[3];
  assign out_ch.r11       = res.r[4];
  assign out_ch.r12       = res.r[5];
  assign out_ch.r20       = res.r[6];
  assign out_ch.r21       = res.r[7];
  assign out_ch.r22       = res.r[8];
  assign out_ch.det_out   = res.det;
  assign out_ch.singular  = res.sing;
  assign out_ch.saturated = res.sat;

endmodule

### rtl/m3i_front.sv
// products, adjugate, exact determinant and divider setup in six stages
module m3i_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  m3i_pkg::mat_t   mat,
  output logic            out_valid,
  input  logic            out_ready,
  output m3i_pkg::div_t   out_d
);

  localparam int ELEM_W = m3i_pkg::ELEM_W;
  localparam int PROD_W = m3i_pkg::PROD_W;
  localparam int COF_W  = m3i_pkg::COF_W;
  localparam int CMAG_W = m3i_pkg::CMAG_W;
  localparam int DET_W  = m3i_pkg::DET_W;
  localparam int DMAG_W = m3i_pkg::DMAG_W;
  localparam int N_ENT  = m3i_pkg::N_ENT;
  localparam int N_PROD = m3i_pkg::N_PROD;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  logic [N_PROD-1:0][PROD_W-1:0] p1_nxt, p1_r;
  logic [2:0][ELEM_W-1:0]        a1_r, a2_r;
  logic [N_ENT-1:0][COF_W-1:0]   cof2_nxt, cof2_r, cof3_r;
  logic [2:0][COF_W-1:0]         pl3_nxt, ph3_nxt, pl3_r, ph3_r;
  logic [2:0][DET_W-1:0]         t4_nxt, t4_r;
  logic [N_ENT-1:0][CMAG_W-1:0]  cm4_nxt, cm4_r, cm5_r;
  logic [N_ENT-1:0]              cn4_nxt, cn4_r, cn5_r;
  logic [DET_W-1:0]              det5_nxt, det5_r;
  m3i_pkg::div_t                 d6_nxt, d6_r;

  // stage handshake: a stage takes new data when empty or when it drains
  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // stage 1: the eighteen 2x2 products
  always_comb begin
    logic signed [ELEM_W-1:0] xa, xb;
    logic signed [PROD_W-1:0] pp;
    p1_nxt = '0;
    for (int k = 0; k < N_ENT; k++) begin
      xa = mat[m3i_pkg::COF_IDX[k][0]];
      xb = mat[m3i_pkg::COF_IDX[k][1]];
      pp = xa * xb;
      p1_nxt[2*k] = pp;
      xa = mat[m3i_pkg::COF_IDX[k][2]];
      xb = mat[m3i_pkg::COF_IDX[k][3]];
      pp = xa * xb;
      p1_nxt[2*k+1] = pp;
    end
  end

  // stage 2: adjugate entries
  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      cof2_nxt[k] = {p1_r[2*k][PROD_W-1], p1_r[2*k]}
                  - {p1_r[2*k+1][PROD_W-1], p1_r[2*k+1]};
    end
  end

  // stage 3: first row times first adjugate column, split in halves
  always_comb begin
    logic signed [ELEM_W-1:0] xa;
    logic signed [ELEM_W:0]   yl, yh;
    logic signed [COF_W-1:0]  pw;
    for (int j = 0; j < 3; j++) begin
      xa = a2_r[j];
      yl = {1'b0, cof2_r[3*j][ELEM_W-1:0]};
      yh = cof2_r[3*j][COF_W-1:ELEM_W];
      pw = xa * yl;
      pl3_nxt[j] = pw;
      pw = xa * yh;
      ph3_nxt[j] = pw;
    end
  end

  // stage 4: join halves, cofactor magnitudes and signs
  always_comb begin
    logic [COF_W-1:0] negc;
    for (int j = 0; j < 3; j++) begin
      t4_nxt[j] = {ph3_r[j], {ELEM_W{1'b0}}}
                + {{(DET_W-COF_W){pl3_r[j][COF_W-1]}}, pl3_r[j]};
    end
    for (int k = 0; k < N_ENT; k++) begin
      negc       = ~cof3_r[k] + 1'b1;
      cn4_nxt[k] = cof3_r[k][COF_W-1];
      cm4_nxt[k] = cof3_r[k][COF_W-1] ? negc[CMAG_W-1:0] : cof3_r[k][CMAG_W-1:0];
    end
  end

  // stage 5: exact determinant
  assign det5_nxt = t4_r[0] + t4_r[1] + t4_r[2];

  // stage 6: determinant magnitude, clipped output, divider start values
  always_comb begin
    logic [DET_W-1:0] dabs;
    m3i_pkg::sat_t    ds;
    dabs = det5_r[DET_W-1] ? (~det5_r + 1'b1) : det5_r;
    ds   = m3i_pkg::sat32(dabs[DMAG_W-1:ELEM_W], det5_r[DET_W-1], 1'b0);
    d6_nxt.dmag    = dabs[DMAG_W-1:0];
    d6_nxt.sing    = (det5_r == '0);
    d6_nxt.det_q   = ds.val;
    d6_nxt.det_sat = ds.sat;
    d6_nxt.q       = '0;
    for (int k = 0; k < N_ENT; k++) begin
      d6_nxt.rem[k] = {{(DMAG_W-CMAG_W){1'b0}}, cm5_r[k]};
      d6_nxt.neg[k] = cn5_r[k] ^ det5_r[DET_W-1];
      d6_nxt.ovf[k] = ({{(DMAG_W-CMAG_W){1'b0}}, cm5_r[k]} >= dabs[DMAG_W-1:0]);
    end
  end

  // stage data registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p1_r <= p1_nxt;
      a1_r <= mat[2:0];
    end
    if (rdy2 && v1_r) begin
      cof2_r <= cof2_nxt;
      a2_r   <= a1_r;
    end
    if (rdy3 && v2_r) begin
      pl3_r  <= pl3_nxt;
      ph3_r  <= ph3_nxt;
      cof3_r <= cof2_r;
    end
    if (rdy4 && v3_r) begin
      t4_r  <= t4_nxt;
      cm4_r <= cm4_nxt;
      cn4_r <= cn4_nxt;
    end
    if (rdy5 && v4_r) begin
      det5_r <= det5_nxt;
      cm5_r  <= cm4_r;
      cn5_r  <= cn4_r;
    end
    if (rdy6 && v5_r) begin
      d6_r <= d6_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_d     = d6_r;

endmodule

### rtl/m3i_div_stage.sv
// one restoring-division step: one quotient bit for all nine entries
module m3i_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  m3i_pkg::div_t in_d,
  output logic          out_valid,
  input  logic          out_ready,
  output m3i_pkg::div_t out_d
);

  localparam int DMAG_W = m3i_pkg::DMAG_W;
  localparam int Q_W    = m3i_pkg::Q_W;
  localparam int N_ENT  = m3i_pkg::N_ENT;

  logic          v_r;
  m3i_pkg::div_t d_r, d_nxt;

  assign in_ready = !v_r || out_ready;

  // shift remainder, trial subtract, shift in quotient bit
  always_comb begin
    logic [DMAG_W:0] r2, diff;
    d_nxt = in_d;
    for (int k = 0; k < N_ENT; k++) begin
      r2   = {in_d.rem[k], 1'b0};
      diff = r2 - {1'b0, in_d.dmag};
      if (r2 >= {1'b0, in_d.dmag}) begin
        d_nxt.rem[k] = diff[DMAG_W-1:0];
        d_nxt.q[k]   = {in_d.q[k][Q_W-2:0], 1'b1};
      end else begin
        d_nxt.rem[k] = r2[DMAG_W-1:0];
        d_nxt.q[k]   = {in_d.q[k][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_d     = d_r;

endmodule

### rtl/m3i_pack.sv
// output register: quotient clipping, singular masking and flags
module m3i_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  m3i_pkg::div_t in_d,
  output logic          out_valid,
  input  logic          out_ready,
  output m3i_pkg::res_t out_res
);

  localparam int CMAG_W = m3i_pkg::CMAG_W;
  localparam int Q_W    = m3i_pkg::Q_W;
  localparam int N_ENT  = m3i_pkg::N_ENT;

  logic          v_r;
  m3i_pkg::res_t res_r, res_nxt;

  assign in_ready = !v_r || out_ready;

  // clip each quotient; a singular matrix gets zero entries, zero det and no sat flag
  always_comb begin
    m3i_pkg::sat_t s;
    logic          any_sat;
    any_sat = in_d.det_sat;
    for (int k = 0; k < N_ENT; k++) begin
      s = m3i_pkg::sat32({{(CMAG_W-Q_W){1'b0}}, in_d.q[k]}, in_d.neg[k], in_d.ovf[k]);
      res_nxt.r[k] = in_d.sing ? '0 : s.val;
      any_sat      = any_sat | s.sat;
    end
    res_nxt.det  = in_d.sing ? '0 : in_d.det_q;
    res_nxt.sing = in_d.sing;
    res_nxt.sat  = !in_d.sing && any_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_res   = res_r;

endmodule

### rtl/m3i_chk.sv
// port-level checks on the matrix inverse, bound to the top level
`include "assert_macros.svh"

module m3i_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_singular,
  input logic          out_saturated,
  input logic [319:0]  out_word
);

  // a stalled result item stays offered
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // reset empties the pipeline
  `CHK_RST(a_rst_empty, !rst_n, !out_valid)

  // with the output empty every stage has room, so input is open
  `CHK_IMPL(a_in_open, !out_valid, in_ready)

  // a singular item carries an all-zero matrix and no clipping
  `CHK_IMPL(a_sing_zero, out_valid && out_singular, out_word == '0 && !out_saturated)

  // a stalled result item keeps its payload
  `CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))

endmodule

bind matrix3x3_inverse m3i_chk u_m3i_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_singular  (out_ch.singular),
  .out_saturated (out_ch.saturated),
  .out_word      ({out_ch.r00, out_ch.r01, out_ch.r02, out_ch.r10, out_ch.r11,
                   out_ch.r12, out_ch.r20, out_ch.r21, out_ch.r22, out_ch.det_out})
);
